// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/cmap4_pkg.sv =====
// ----------------------------------------------------------------------------
// cmap4_pkg
// Constants, types and codes of the format-4 glyph mapper.
// ----------------------------------------------------------------------------
package cmap4_pkg;

    localparam int MAX_SEGMENTS    = 256;
    localparam int MAX_GLYPH_WORDS = 4096;

    localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int SEG_CW = $clog2(MAX_SEGMENTS + 1);
    localparam int GLY_AW = (MAX_GLYPH_WORDS > 1) ? $clog2(MAX_GLYPH_WORDS) : 1;
    localparam int WRD_CW = $clog2(MAX_GLYPH_WORDS + 1);

    // signed glyph-array index: half offset + code offset + row - rows in use
    localparam int IDX_W = 19;

    localparam logic [15:0] NO_CODE = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_LOAD_SEG  = 2'd0,
        OP_LOAD_WORD = 2'd1,
        OP_LOOKUP    = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CFG_SEG_COUNT   = 2'd0,
        CFG_GLYPH_COUNT = 2'd1,
        CFG_ARRAY_WORDS = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_GWAIT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [15:0] start_code;
        logic [15:0] end_code;
        logic [15:0] id_delta;
        logic [15:0] range_offset;
    } t_seg_row;

endpackage

// ===== src/cmap4_ram.sv =====
// ----------------------------------------------------------------------------
// cmap4_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cmap4_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/cmap_format4_glyph_mapper.sv =====
// ----------------------------------------------------------------------------
// cmap_format4_glyph_mapper
// Maps a 16-bit code point to a glyph index through a loaded format-4
// segment table and glyph array.
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+--------------------------------
//   request  | i_in_valid   | o_in_stall   | i_op, i_slot, segment, word, code
//   result   | o_out_valid  | i_out_stall  | o_glyph, o_found, o_malformed
//   config   | i_cfg_we     | -            | i_cfg_idx, i_cfg_wdata
//
// loads are written as they are taken; a lookup walks the segment RAM with one
// read per cycle and stops at the first matching row or after the rows in use.
// segment and glyph RAMs come up undefined; no clearing pass after reset.
// a lookup waits in its last state while the result register is held by
// i_out_stall; requests are taken only while no lookup is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cmap_format4_glyph_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [11:0] i_slot,
    input  logic [15:0] i_start_code,
    input  logic [15:0] i_end_code,
    input  logic [15:0] i_id_delta,
    input  logic [15:0] i_range_offset,
    input  logic [15:0] i_glyph_word,
    input  logic [15:0] i_code_point,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_glyph,
    output logic        o_found,
    output logic        o_malformed
);
    import cmap4_pkg::*;

    t_state r_state, n_state;

    logic [8:0]  r_seg_count;
    logic [15:0] r_glyph_count;
    logic [12:0] r_array_words;

    logic [15:0]       r_code,    n_code;
    logic [SEG_CW-1:0] r_rd_idx,  n_rd_idx;
    logic              r_pend,    n_pend;
    logic [SEG_CW-1:0] r_chk_idx, n_chk_idx;
    logic              r_direct,  n_direct;
    logic [15:0]       r_g,       n_g;
    logic [15:0]       r_delta,   n_delta;
    logic [IDX_W-1:0]  r_gidx,    n_gidx;
    logic              r_chk,     n_chk;
    logic              r_mal,     n_mal;
    logic              r_out_valid, n_out_valid;
    logic [15:0]       r_glyph,   n_glyph;
    logic              r_found,   n_found;
    logic              r_malformed, n_malformed;

    logic [SEG_CW-1:0] nseg;
    logic [WRD_CW-1:0] nwords;

    logic              seg_we, seg_re;
    logic [SEG_AW-1:0] seg_waddr, seg_raddr;
    t_seg_row          seg_wdata, seg_row;
    logic [$bits(t_seg_row)-1:0] seg_rdata;
    logic              gly_we, gly_re;
    logic [GLY_AW-1:0] gly_waddr, gly_raddr;
    logic [15:0]       gly_rdata;

    logic        in_acc, out_free;
    logic        scan_hit, scan_issue, scan_miss, eval_bad;
    logic [15:0] code_off;

    // ------------------------------------------------------------ memories
    cmap4_ram #(.WIDTH($bits(t_seg_row)), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (seg_we),
        .i_waddr (seg_waddr),
        .i_wdata (seg_wdata),
        .i_re    (seg_re),
        .i_raddr (seg_raddr),
        .o_rdata (seg_rdata)
    );

    cmap4_ram #(.WIDTH(16), .DEPTH(MAX_GLYPH_WORDS)) u_gly_ram (
        .i_clk   (i_clk),
        .i_we    (gly_we),
        .i_waddr (gly_waddr),
        .i_wdata (i_glyph_word),
        .i_re    (gly_re),
        .i_raddr (gly_raddr),
        .o_rdata (gly_rdata)
    );

    // ------------------------------------------------------------ decode
    assign seg_row = t_seg_row'(seg_rdata);

    assign nseg   = (32'(r_seg_count) > MAX_SEGMENTS) ? SEG_CW'(MAX_SEGMENTS)
                                                      : SEG_CW'(r_seg_count);
    assign nwords = (32'(r_array_words) > MAX_GLYPH_WORDS) ? WRD_CW'(MAX_GLYPH_WORDS)
                                                           : WRD_CW'(r_array_words);

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign scan_hit   = r_pend
                     && (seg_row.start_code != NO_CODE) && (seg_row.end_code != NO_CODE)
                     && (r_code >= seg_row.start_code) && (r_code <= seg_row.end_code);
    assign scan_issue = !scan_hit && (r_rd_idx < nseg);
    assign scan_miss  = !r_pend && !(r_rd_idx < nseg);
    assign eval_bad   = r_gidx[IDX_W-1] || (r_gidx >= IDX_W'(nwords));
    assign code_off   = r_code - seg_row.start_code;

    // ------------------------------------------------------------ next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_op == OP_LOOKUP)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_state = S_EVAL;
                end else if (scan_miss) begin
                    n_state = S_FIN;
                end
            end
            S_EVAL: begin
                if (r_direct || eval_bad) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_GWAIT;
                end
            end
            S_GWAIT: n_state = S_FIN;
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------ datapath
    always_comb begin
        seg_we    = 1'b0;
        seg_waddr = SEG_AW'(i_slot);
        seg_wdata = '{start_code: i_start_code, end_code: i_end_code,
                      id_delta: i_id_delta, range_offset: i_range_offset};
        seg_re    = 1'b0;
        seg_raddr = r_rd_idx[SEG_AW-1:0];
        gly_we    = 1'b0;
        gly_waddr = GLY_AW'(i_slot);
        gly_re    = 1'b0;
        gly_raddr = GLY_AW'(r_gidx);

        n_code    = r_code;
        n_rd_idx  = r_rd_idx;
        n_pend    = 1'b0;
        n_chk_idx = r_chk_idx;
        n_direct  = r_direct;
        n_g       = r_g;
        n_delta   = r_delta;
        n_gidx    = r_gidx;
        n_chk     = r_chk;
        n_mal     = r_mal;
        n_glyph     = r_glyph;
        n_found     = r_found;
        n_malformed = r_malformed;
        n_out_valid = i_out_stall ? r_out_valid : 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_op)
                        OP_LOAD_SEG:  seg_we = (32'(i_slot) < MAX_SEGMENTS);
                        OP_LOAD_WORD: gly_we = (32'(i_slot) < MAX_GLYPH_WORDS);
                        OP_LOOKUP: begin
                            n_code   = i_code_point;
                            n_rd_idx = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_direct = (seg_row.range_offset == 16'd0);
                    n_g      = r_code + seg_row.id_delta;
                    n_delta  = seg_row.id_delta;
                    n_gidx   = IDX_W'({1'b0, seg_row.range_offset[15:1]})
                             + IDX_W'(code_off) + IDX_W'(r_chk_idx) - IDX_W'(nseg);
                end else if (scan_issue) begin
                    seg_re    = 1'b1;
                    n_rd_idx  = r_rd_idx + SEG_CW'(1);
                    n_pend    = 1'b1;
                    n_chk_idx = r_rd_idx;
                end else if (scan_miss) begin
                    n_chk = 1'b0;
                    n_mal = 1'b0;
                end
            end
            S_EVAL: begin
                n_mal = 1'b0;
                if (r_direct) begin
                    n_chk = 1'b1;
                end else if (eval_bad) begin
                    n_chk = 1'b0;
                    n_mal = 1'b1;
                end else begin
                    gly_re = 1'b1;
                end
            end
            S_GWAIT: begin
                // zero word means glyph 0, delta not applied
                n_g   = (gly_rdata != 16'd0) ? (gly_rdata + r_delta) : 16'd0;
                n_chk = 1'b1;
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_found     = r_chk && (r_g < r_glyph_count);
                    n_glyph     = (r_chk && (r_g < r_glyph_count)) ? r_g : 16'd0;
                    n_malformed = r_mal;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_seg_count   <= '0;
            r_glyph_count <= '0;
            r_array_words <= '0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SEG_COUNT:   r_seg_count   <= i_cfg_wdata[8:0];
                    CFG_GLYPH_COUNT: r_glyph_count <= i_cfg_wdata;
                    CFG_ARRAY_WORDS: r_array_words <= i_cfg_wdata[12:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_code      <= n_code;
        r_rd_idx    <= n_rd_idx;
        r_chk_idx   <= n_chk_idx;
        r_direct    <= n_direct;
        r_g         <= n_g;
        r_delta     <= n_delta;
        r_gidx      <= n_gidx;
        r_chk       <= n_chk;
        r_mal       <= n_mal;
        r_glyph     <= n_glyph;
        r_found     <= n_found;
        r_malformed <= n_malformed;
    end

    assign o_out_valid = r_out_valid;
    assign o_glyph     = r_glyph;
    assign o_found     = r_found;
    assign o_malformed = r_malformed;

    // ------------------------------------------------------------ checks
    `ASSERT_SAME(a_seg_read_in_use, seg_re, r_rd_idx < nseg, "segment read past rows in use")
    `ASSERT_SAME(a_gly_read_in_range, gly_re, !eval_bad, "glyph read outside loaded words")
    `ASSERT_NEXT(a_result_from_fin, !o_out_valid && r_state != S_FIN, !o_out_valid, "stray result")
    `ASSERT_SAME(a_found_not_malformed, o_out_valid, !(o_found && o_malformed), "both flags set")

endmodule

// ===== sim/cmap_format4_glyph_mapper_test.sv =====
// ----------------------------------------------------------------------------
// cmap_format4_glyph_mapper_test
// Self-checking bench for the format-4 glyph mapper. A directed part loads a
// small segment table and glyph array that hit the direct and array-indexed
// paths, skipped rows, wrap of the delta, zero words, odd offsets,
// out-of-range indices, the glyph count limit and ignored requests. Random
// rounds then build well-formed tables with noise rows, change the registers
// between rounds (limits included) and look up mostly mapped code points
// under random gaps and output stalls. Every result is checked against a
// predictor kept in the bench.
// ----------------------------------------------------------------------------
module cmap_format4_glyph_mapper_test;
    import cmap4_pkg::*;

    localparam logic [1:0] OP_RSVD = 2'd3;
    localparam int ITEM_TARGET = 1900;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] slot;
        t_seg_row    row;
        logic [15:0] word;
        logic [15:0] code;
    } t_req;

    typedef struct packed {
        logic [15:0] glyph;
        logic        found;
        logic        malformed;
    } t_glyph_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = 2'd0;
    logic [15:0] i_cfg_wdata = 16'd0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op = 2'd0;
    logic [11:0] i_slot = 12'd0;
    logic [15:0] i_start_code = 16'd0;
    logic [15:0] i_end_code = 16'd0;
    logic [15:0] i_id_delta = 16'd0;
    logic [15:0] i_range_offset = 16'd0;
    logic [15:0] i_glyph_word = 16'd0;
    logic [15:0] i_code_point = 16'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_glyph;
    logic        o_found;
    logic        o_malformed;

    // bench copy of the mapper state
    t_seg_row    seg_tab [MAX_SEGMENTS];
    logic [15:0] word_tab [MAX_GLYPH_WORDS];
    bit          row_loaded [MAX_SEGMENTS];
    bit          word_loaded [MAX_GLYPH_WORDS];
    int unsigned seg_rows;
    int unsigned glyph_max;
    int unsigned array_words;

    t_glyph_res  pending_maps [$];
    int          fail_cnt = 0;
    int          sent_cnt = 0;
    int          cycle_cnt = 0;
    bit          no_idle = 1'b0;
    int          stall_left = 0;
    int          stall_len;

    cmap_format4_glyph_mapper u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_slot         (i_slot),
        .i_start_code   (i_start_code),
        .i_end_code     (i_end_code),
        .i_id_delta     (i_id_delta),
        .i_range_offset (i_range_offset),
        .i_glyph_word   (i_glyph_word),
        .i_code_point   (i_code_point),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_glyph        (o_glyph),
        .o_found        (o_found),
        .o_malformed    (o_malformed)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (no_idle || pick < 50)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // walk the table as the mapper does; returns 0 if an unloaded entry would be read
    function automatic bit map_code(input logic [15:0] code, output t_glyph_res res);
        int          rows;
        int          words;
        int          i;
        int          idx;
        logic [15:0] w;
        logic [15:0] g;
        res = '0;
        rows = (seg_rows > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_rows;
        words = (array_words > MAX_GLYPH_WORDS) ? MAX_GLYPH_WORDS : array_words;
        for (i = 0; i < rows; i++) begin
            if (!row_loaded[i])
                return 1'b0;
            if (seg_tab[i].start_code == NO_CODE || seg_tab[i].end_code == NO_CODE)
                continue;
            if (code < seg_tab[i].start_code || code > seg_tab[i].end_code)
                continue;
            if (seg_tab[i].range_offset == 16'd0) begin
                g = code + seg_tab[i].id_delta;
            end else begin
                idx = int'(seg_tab[i].range_offset >> 1) + int'(code)
                    - int'(seg_tab[i].start_code) + i - rows;
                if (idx < 0 || idx >= words) begin
                    res.malformed = 1'b1;
                    return 1'b1;
                end
                if (!word_loaded[idx])
                    return 1'b0;
                w = word_tab[idx];
                g = (w != 16'd0) ? w + seg_tab[i].id_delta : 16'd0;
            end
            if (g < glyph_max) begin
                res.glyph = g;
                res.found = 1'b1;
            end
            return 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic t_req rand_req(input logic [1:0] op);
        t_req r;
        r.op = op;
        r.slot = 12'($urandom);
        r.row = {$urandom, $urandom};
        r.word = 16'($urandom);
        r.code = 16'($urandom);
        return r;
    endfunction

    task automatic send_req(input t_req r);
        int         gap;
        t_glyph_res res;
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= r.op;
        i_slot <= r.slot;
        i_start_code <= r.row.start_code;
        i_end_code <= r.row.end_code;
        i_id_delta <= r.row.id_delta;
        i_range_offset <= r.row.range_offset;
        i_glyph_word <= r.word;
        i_code_point <= r.code;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        case (r.op)
            OP_LOAD_SEG: begin
                if (r.slot < MAX_SEGMENTS) begin
                    seg_tab[r.slot[SEG_AW-1:0]] = r.row;
                    row_loaded[r.slot[SEG_AW-1:0]] = 1'b1;
                    sent_cnt++;
                end
            end
            OP_LOAD_WORD: begin
                word_tab[r.slot] = r.word;
                word_loaded[r.slot] = 1'b1;
                sent_cnt++;
            end
            OP_LOOKUP: begin
                void'(map_code(r.code, res));
                pending_maps.push_back(res);
                sent_cnt++;
            end
            default: ;
        endcase
    endtask

    task automatic load_row(input int slot, input t_seg_row row);
        t_req r;
        r = rand_req(OP_LOAD_SEG);
        r.slot = 12'(slot);
        r.row = row;
        send_req(r);
    endtask

    task automatic load_word(input int slot, input logic [15:0] w);
        t_req r;
        r = rand_req(OP_LOAD_WORD);
        r.slot = 12'(slot);
        r.word = w;
        send_req(r);
    endtask

    task automatic look_up(input logic [15:0] code);
        t_req r;
        r = rand_req(OP_LOOKUP);
        r.code = code;
        send_req(r);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_maps.size() > 0) @(posedge i_clk);
    endtask

    // registers change only with the mapper idle
    task automatic write_regs(input int segs, input int glyphs, input int words);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_SEG_COUNT;
        i_cfg_wdata <= 16'(segs);
        @(posedge i_clk);
        i_cfg_idx <= CFG_GLYPH_COUNT;
        i_cfg_wdata <= 16'(glyphs);
        @(posedge i_clk);
        i_cfg_idx <= CFG_ARRAY_WORDS;
        i_cfg_wdata <= 16'(words);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        seg_rows = segs & 9'h1FF;
        glyph_max = glyphs & 16'hFFFF;
        array_words = words & 13'h1FFF;
    endtask

    task automatic test_empty_table();
        look_up(16'h1234);
    endtask

    task automatic test_ignored_items();
        t_req r;
        r = rand_req(OP_RSVD);
        send_req(r);
        r = rand_req(OP_LOAD_SEG);
        r.slot = 12'(MAX_SEGMENTS);
        send_req(r);
    endtask

    task automatic test_format4_table();
        write_regs(4, 1000, 4);
        // end code 0xffff makes this row invisible
        load_row(0, '{16'h0041, 16'hFFFF, 16'd5, 16'd0});
        load_row(1, '{16'h0000, 16'h0040, 16'hFFFF, 16'd0});
        // odd offset, low bit dropped
        load_row(2, '{16'h0100, 16'h0103, 16'd3, 16'd5});
        load_row(3, '{16'h0300, 16'h030F, 16'd0, 16'd1});
        load_word(0, 16'd0);
        load_word(1, 16'd100);
        load_word(2, 16'd997);
        load_word(3, 16'hFFFE);
        look_up(16'h0000);
        look_up(16'h0001);
        look_up(16'h0040);
        look_up(16'h0100);
        look_up(16'h0101);
        look_up(16'h0102);
        look_up(16'h0103);
        look_up(16'h0300);
        look_up(16'h0301);
        look_up(16'h0305);
        look_up(16'hFFFF);
    endtask

    task automatic test_config_limits();
        write_regs(4, 0, 4);
        look_up(16'h0101);
        write_regs(4, 1000, 0);
        look_up(16'h0101);
    endtask

    task automatic test_random_tables();
        int         round_idx;
        int         big_left;
        int         rows_used;
        int         seg_val;
        int         glyph_val;
        int         word_val;
        int         max_len;
        int         spread;
        int         cursor;
        int         len;
        int         hi;
        int         base;
        int         kind;
        int         n_look;
        int         i;
        int         k;
        int         tries;
        bit         ok;
        logic [15:0] code;
        t_seg_row   row;
        t_glyph_res res;
        t_req       r;
        round_idx = 0;
        big_left = 3;
        while (sent_cnt < ITEM_TARGET) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if (round_idx % 5 == 2 && big_left > 0) begin
                seg_val = (big_left == 3) ? MAX_SEGMENTS : $urandom_range(257, 511);
                big_left--;
            end else if (round_idx % 7 == 3) begin
                seg_val = 0;
            end else begin
                seg_val = $urandom_range(1, 12);
            end
            rows_used = (seg_val > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_val;
            case ($urandom_range(0, 9))
                0: glyph_val = 0;
                1: glyph_val = $urandom_range(1, 300);
                2: glyph_val = $urandom_range(0, 16'hFFFF);
                default: glyph_val = 16'hFFFF;
            endcase
            case ($urandom_range(0, 9))
                0: word_val = 0;
                1: word_val = $urandom_range(1, MAX_GLYPH_WORDS);
                2: word_val = $urandom_range(0, 1) ? 8191 : $urandom_range(4097, 8190);
                default: word_val = MAX_GLYPH_WORDS;
            endcase
            write_regs(seg_val, glyph_val, word_val);

            max_len = (rows_used > 32) ? 2 : 16;
            spread = 60000 / (rows_used + 1);
            cursor = $urandom_range(0, 255);
            for (i = 0; i < rows_used; i++) begin
                kind = $urandom_range(0, 99);
                row = {$urandom, $urandom};
                if (kind < 10) begin
                    // noise row, fields as drawn
                end else if (kind < 18) begin
                    if ($urandom_range(0, 1))
                        row.start_code = NO_CODE;
                    else
                        row.end_code = NO_CODE;
                end else begin
                    len = $urandom_range(1, max_len);
                    hi = cursor + len - 1;
                    row.start_code = 16'(cursor);
                    row.end_code = (hi > 16'hFFFE) ? 16'hFFFE : 16'(hi);
                    if ($urandom_range(0, 9) < 4) begin
                        row.range_offset = 16'd0;
                    end else begin
                        base = $urandom_range(0, MAX_GLYPH_WORDS - len);
                        row.range_offset = 16'(2 * (base - i + rows_used)
                                         + ($urandom_range(0, 9) == 0));
                        for (k = 0; k < len; k++)
                            load_word(base + k, ($urandom_range(0, 4) == 0) ? 16'd0
                                                                           : 16'($urandom));
                    end
                    cursor = cursor + len + $urandom_range(0, spread);
                    if (cursor > 16'hFFF0)
                        cursor = $urandom_range(0, 255);
                end
                load_row(i, row);
            end

            n_look = (rows_used > 32) ? 40 : $urandom_range(30, 60);
            for (k = 0; k < n_look; k++) begin
                if ($urandom_range(0, 99) < 6) begin
                    case ($urandom_range(0, 2))
                        0: r = rand_req(OP_RSVD);
                        1: begin
                            r = rand_req(OP_LOAD_SEG);
                            r.slot = 12'($urandom_range(MAX_SEGMENTS, 4095));
                        end
                        default: r = rand_req(OP_LOAD_WORD);
                    endcase
                    send_req(r);
                end
                if ($urandom_range(0, 99) < 3)
                    drain();
                ok = 1'b0;
                for (tries = 0; tries < 8 && !ok; tries++) begin
                    if (rows_used > 0 && $urandom_range(0, 3) != 0) begin
                        i = $urandom_range(0, rows_used - 1);
                        code = 16'($urandom_range(seg_tab[i].start_code,
                                                  seg_tab[i].end_code));
                    end else begin
                        code = 16'($urandom);
                    end
                    ok = map_code(code, res);
                end
                if (ok)
                    look_up(code);
            end
            round_idx++;
        end
        no_idle = 1'b0;
    endtask

    // result side: random stall and in-order compare
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_maps.size() == 0) begin
                    $error("glyph: no result expected, actual %0d", o_glyph);
                    fail_cnt++;
                end else begin
                    if (o_glyph !== pending_maps[0].glyph) begin
                        $error("glyph: expected %0d, actual %0d",
                               pending_maps[0].glyph, o_glyph);
                        fail_cnt++;
                    end
                    if (o_found !== pending_maps[0].found) begin
                        $error("found: expected %0d, actual %0d",
                               pending_maps[0].found, o_found);
                        fail_cnt++;
                    end
                    if (o_malformed !== pending_maps[0].malformed) begin
                        $error("malformed: expected %0d, actual %0d",
                               pending_maps[0].malformed, o_malformed);
                        fail_cnt++;
                    end
                    void'(pending_maps.pop_front());
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
            end else if (i_out_stall || no_idle) begin
                i_out_stall <= 1'b0;
                stall_left <= $urandom_range(0, 7);
            end else begin
                stall_len = idle_len();
                i_out_stall <= (stall_len > 0);
                stall_left <= stall_len;
            end
        end
    end

    initial begin
        seg_rows = 0;
        glyph_max = 0;
        array_words = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_ignored_items();
        test_format4_table();
        test_config_limits();
        test_random_tables();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && pending_maps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/cmap4_pkg.sv
src/cmap4_ram.sv
src/cmap_format4_glyph_mapper.sv
sim/cmap_format4_glyph_mapper_test.sv
